// File: rtl/lvw3d_pkg.sv
// Package for the 3D line voxel walker: coordinate widths, default span limit
// and the setup flag struct. No dependencies.
package lvw3d_pkg;

  localparam int COORD_W      = 26;
  localparam int DELTA_W      = COORD_W + 1;
  localparam int MAX_SPAN_DEF = 63;
  localparam int NUM_AXES     = 3;

  typedef struct packed {
    logic zero;
    logic over;
  } setup_flags_t;

endpackage

// File: rtl/line_voxel_walker_3d_unit.sv
// 3D line voxel walker top level: command port, sequencer and output register.
// Depends on lvw3d_pkg, lvw3d_setup and lvw3d_step.
// The first voxel strobes from the output register after the setup state and the first walk state.
// While busy the unit passes through the setup state, then takes one step of the shared step
// unit per voxel; a new line is taken only when idle.
// Reset (rst_n low, synchronous) returns to idle with no strobe; the receiver cannot stall.
module line_voxel_walker_3d_unit import lvw3d_pkg::*; #(
  parameter int MAX_SPAN = MAX_SPAN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic signed [COORD_W-1:0] in_end_z,
  output logic                     out_valid,
  output logic signed [COORD_W-1:0] out_voxel_x,
  output logic signed [COORD_W-1:0] out_voxel_y,
  output logic signed [COORD_W-1:0] out_voxel_z,
  output logic                     out_last_voxel,
  output logic                     out_span_error
);

  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int REM_W  = SPAN_W + 3;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;

  logic signed [DELTA_W-1:0] delta_r  [NUM_AXES];
  logic signed [COORD_W-1:0] coord_r  [NUM_AXES];
  logic signed [REM_W-1:0]   rem_r    [NUM_AXES];
  logic signed [REM_W-1:0]   two_d_r  [NUM_AXES];
  logic signed [REM_W-1:0]   two_a_r;
  logic        [SPAN_W-1:0]  span_r;
  logic        [SPAN_W-1:0]  t_r;
  logic signed [COORD_W-1:0] vox_r    [NUM_AXES];
  logic                      last_r;
  logic                      err_r;

  logic signed [COORD_W-1:0] in_start [NUM_AXES];
  logic signed [COORD_W-1:0] in_end   [NUM_AXES];
  logic signed [COORD_W-1:0] coord_step [NUM_AXES];
  logic signed [REM_W-1:0]   rem_step   [NUM_AXES];
  setup_flags_t              flags;
  logic        [SPAN_W-1:0]  span;
  logic                      accept;
  logic                      at_last;

  assign in_start[0] = in_start_x;
  assign in_start[1] = in_start_y;
  assign in_start[2] = in_start_z;
  assign in_end[0]   = in_end_x;
  assign in_end[1]   = in_end_y;
  assign in_end[2]   = in_end_z;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign at_last = (t_r == span_r);

  lvw3d_setup #(
    .MAX_SPAN (MAX_SPAN),
    .SPAN_W   (SPAN_W)
  ) u_setup (
    .delta_i (delta_r),
    .flags_o (flags),
    .span_o  (span)
  );

  lvw3d_step #(
    .SPAN_W (SPAN_W),
    .REM_W  (REM_W)
  ) u_step (
    .coord_i (coord_r),
    .rem_i   (rem_r),
    .two_d_i (two_d_r),
    .two_a_i (two_a_r),
    .coord_o (coord_step),
    .rem_o   (rem_step)
  );

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        priority if (flags.zero) begin
          state_nxt = ST_IDLE;
        end else if (flags.over) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        valid_nxt = 1'b1;
        if (at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        delta_r[i] <= DELTA_W'(in_end[i]) - DELTA_W'(in_start[i]);
        coord_r[i] <= in_start[i];
      end
    end else if (state_r == ST_SETUP) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        rem_r[i]   <= REM_W'({3'b000, span});
        two_d_r[i] <= {delta_r[i][REM_W-2:0], 1'b0};
      end
      two_a_r <= REM_W'({2'b00, span, 1'b0});
      span_r  <= span;
      t_r     <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        vox_r[i] <= '0;
      end
      last_r <= 1'b0;
      err_r  <= flags.over;
    end else if (state_r == ST_WALK) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        vox_r[i]   <= coord_r[i];
        coord_r[i] <= coord_step[i];
        rem_r[i]   <= rem_step[i];
      end
      last_r <= at_last;
      err_r  <= 1'b0;
      t_r    <= t_r + SPAN_W'(1);
    end
  end

  assign out_valid      = valid_r;
  assign out_voxel_x    = vox_r[0];
  assign out_voxel_y    = vox_r[1];
  assign out_voxel_z    = vox_r[2];
  assign out_last_voxel = last_r;
  assign out_span_error = err_r;

endmodule

// File: rtl/lvw3d_setup.sv
// Line setup: sizes the walk from the largest endpoint delta magnitude and flags zero or over-limit spans.
// Depends on lvw3d_pkg.
module lvw3d_setup import lvw3d_pkg::*; #(
  parameter int MAX_SPAN = MAX_SPAN_DEF,
  parameter int SPAN_W   = $clog2(MAX_SPAN + 1)
) (
  input  logic signed [DELTA_W-1:0] delta_i [NUM_AXES],
  output setup_flags_t              flags_o,
  output logic        [SPAN_W-1:0]  span_o
);

  logic [DELTA_W-1:0] mag [NUM_AXES];
  logic [DELTA_W-1:0] span_full;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i] = delta_i[i][DELTA_W-1] ? DELTA_W'(-delta_i[i]) : DELTA_W'(delta_i[i]);
    end
    span_full = mag[0];
    for (int i = 1; i < NUM_AXES; i++) begin
      if (mag[i] > span_full) begin
        span_full = mag[i];
      end
    end
  end

  assign flags_o.zero = (span_full == '0);
  assign flags_o.over = (span_full > DELTA_W'(MAX_SPAN));
  assign span_o       = span_full[SPAN_W-1:0];

endmodule

// File: rtl/lvw3d_step.sv
// Walk step unit: advances all three coordinates by one line step using the
// exact remainder update. Depends on lvw3d_pkg.
module lvw3d_step import lvw3d_pkg::*; #(
  parameter int SPAN_W = $clog2(MAX_SPAN_DEF + 1),
  parameter int REM_W  = SPAN_W + 3
) (
  input  logic signed [COORD_W-1:0] coord_i [NUM_AXES],
  input  logic signed [REM_W-1:0]   rem_i   [NUM_AXES],
  input  logic signed [REM_W-1:0]   two_d_i [NUM_AXES],
  input  logic signed [REM_W-1:0]   two_a_i,
  output logic signed [COORD_W-1:0] coord_o [NUM_AXES],
  output logic signed [REM_W-1:0]   rem_o   [NUM_AXES]
);

  logic signed [REM_W-1:0] sum [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sum[i] = rem_i[i] + two_d_i[i];
      priority if (sum[i] >= two_a_i) begin
        rem_o[i]   = sum[i] - two_a_i;
        coord_o[i] = coord_i[i] + COORD_W'(1);
      end else if (sum[i] < 0) begin
        rem_o[i]   = sum[i] + two_a_i;
        coord_o[i] = coord_i[i] - COORD_W'(1);
      end else begin
        rem_o[i]   = sum[i];
        coord_o[i] = coord_i[i];
      end
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench for line_voxel_walker_3d_unit: directed and random line requests, with every
// voxel predicted in a scoreboard class and checked against the output strobe.
// Depends on lvw3d_pkg and the RTL top level.
module tb_top import lvw3d_pkg::*;;

  localparam int     SPAN_LIMIT = MAX_SPAN_DEF;
  localparam longint COORD_MAX  = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN  = -COORD_MAX - 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t pa[NUM_AXES];
    coord_t pb[NUM_AXES];
  } line_t;

  typedef struct {
    coord_t pos[NUM_AXES];
    logic   last;
    logic   err;
  } voxel_t;

  class voxel_scoreboard;
    voxel_t expected_voxels[$];
    int     mismatches;
    int     voxels_checked;
    int     lines_noted;
    int     span_errors;
    int     empty_lines;

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    static function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    static function longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
    endfunction

    function int pending();
      return expected_voxels.size();
    endfunction

    // Walk the line along its dominant axis; minor axes round half up.
    function void note_request(line_t ln);
      longint st[NUM_AXES];
      longint dl[NUM_AXES];
      longint span;
      longint dir;
      longint t;
      int     major;
      int     a;
      voxel_t v;
      major = 0;
      lines_noted++;
      for (a = 0; a < NUM_AXES; a++) begin
        st[a] = ln.pa[a];
        dl[a] = longint'(ln.pb[a]) - st[a];
        if (mag(dl[a]) > mag(dl[major])) major = a;
      end
      if (dl[major] == 0) begin
        empty_lines++;
        return;
      end
      span = mag(dl[major]);
      if (span > SPAN_LIMIT) begin
        for (a = 0; a < NUM_AXES; a++) v.pos[a] = '0;
        v.last = 1'b0;
        v.err  = 1'b1;
        expected_voxels.push_back(v);
        span_errors++;
        return;
      end
      dir = (dl[major] > 0) ? 1 : -1;
      for (t = 0; t <= span; t++) begin
        for (a = 0; a < NUM_AXES; a++) begin
          if (a == major) v.pos[a] = coord_t'(st[a] + dir * t);
          else v.pos[a] = coord_t'(st[a] + floor_div(2 * t * dl[a] + span, 2 * span));
        end
        v.last = (t == span);
        v.err  = 1'b0;
        expected_voxels.push_back(v);
      end
    endfunction

    task check_voxel(voxel_t got);
      voxel_t want;
      int     a;
      if (expected_voxels.size() == 0) begin
        report("voxel strobed with no request pending");
        return;
      end
      want = expected_voxels.pop_front();
      voxels_checked++;
      for (a = 0; a < NUM_AXES; a++)
        if (got.pos[a] !== want.pos[a])
          report($sformatf("voxel %0d axis %0d: got %0d, expected %0d",
                           voxels_checked, a, got.pos[a], want.pos[a]));
      if (got.last !== want.last)
        report($sformatf("voxel %0d last_voxel: got %b, expected %b",
                         voxels_checked, got.last, want.last));
      if (got.err !== want.err)
        report($sformatf("voxel %0d span_error: got %b, expected %b",
                         voxels_checked, got.err, want.err));
    endtask
  endclass

  logic   clk   = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_start_z = '0;
  coord_t in_end_x   = '0;
  coord_t in_end_y   = '0;
  coord_t in_end_z   = '0;
  logic   out_valid;
  coord_t out_voxel_x;
  coord_t out_voxel_y;
  coord_t out_voxel_z;
  logic   out_last_voxel;
  logic   out_span_error;

  voxel_scoreboard sb = new();
  int idle_pct = 0;

  line_voxel_walker_3d_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_start_z     (in_start_z),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_end_z       (in_end_z),
    .out_valid      (out_valid),
    .out_voxel_x    (out_voxel_x),
    .out_voxel_y    (out_voxel_y),
    .out_voxel_z    (out_voxel_z),
    .out_last_voxel (out_last_voxel),
    .out_span_error (out_span_error)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    voxel_t got;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      got.pos[0] = out_voxel_x;
      got.pos[1] = out_voxel_y;
      got.pos[2] = out_voxel_z;
      got.last   = out_last_voxel;
      got.err    = out_span_error;
      sb.check_voxel(got);
    end
  end

  task automatic send_line(input longint sx, sy, sz, ex, ey, ez);
    line_t ln;
    ln.pa[0] = coord_t'(sx);
    ln.pa[1] = coord_t'(sy);
    ln.pa[2] = coord_t'(sz);
    ln.pb[0] = coord_t'(ex);
    ln.pb[1] = coord_t'(ey);
    ln.pb[2] = coord_t'(ez);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_start_x <= ln.pa[0];
    in_start_y <= ln.pa[1];
    in_start_z <= ln.pa[2];
    in_end_x   <= ln.pb[0];
    in_end_y   <= ln.pb[1];
    in_end_z   <= ln.pb[2];
    start      <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(ln);
  endtask

  // Hold the request port quiet until every expected voxel has come out.
  task automatic drain;
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic longint rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX - longint'($urandom_range(70));
      1:       return COORD_MIN + longint'($urandom_range(70));
      default: return longint'($urandom_range(32'h3FFFFFF)) + COORD_MIN;
    endcase
  endfunction

  task automatic send_random_line;
    longint st[NUM_AXES];
    longint en[NUM_AXES];
    longint d[NUM_AXES];
    longint s;
    int     kind;
    int     major;
    int     tie_axis;
    int     a;
    kind = $urandom_range(99);
    for (a = 0; a < NUM_AXES; a++) st[a] = rand_coord();
    if (kind < 8) begin
      for (a = 0; a < NUM_AXES; a++) en[a] = st[a];
    end else if (kind < 14) begin
      for (a = 0; a < NUM_AXES; a++) en[a] = rand_coord();
    end else begin
      if (kind < 20) s = $urandom_range(64, 200);
      else if (kind < 45) s = $urandom_range(1, 4);
      else s = $urandom_range(1, SPAN_LIMIT);
      major = $urandom_range(NUM_AXES - 1);
      for (a = 0; a < NUM_AXES; a++)
        d[a] = longint'($urandom_range(2 * s)) - s;
      d[major] = $urandom_range(1) ? s : -s;
      if (kind >= 90) begin
        tie_axis = $urandom_range(NUM_AXES - 1);
        d[tie_axis] = $urandom_range(1) ? s : -s;
      end
      for (a = 0; a < NUM_AXES; a++) begin
        en[a] = st[a] + d[a];
        if (en[a] > COORD_MAX || en[a] < COORD_MIN) en[a] = st[a] - d[a];
      end
    end
    send_line(st[0], st[1], st[2], en[0], en[1], en[2]);
  endtask

  task automatic run_random(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      send_random_line();
      if (i == count / 2 && pct == 24) drain();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 24;
    send_line(0, 0, 0, 0, 0, 0);
    send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_line(0, 0, 0, 1, 0, 0);
    send_line(0, 0, 0, 0, -1, 0);
    send_line(0, 0, 0, 0, 0, 1);
    send_line(0, 0, 0, 63, -20, 31);
    send_line(5, -7, 100, 10, 56, 70);
    send_line(0, 0, 0, -30, 40, -63);
    send_line(0, 0, 0, 63, 62, 1);
    send_line(0, 0, 0, 64, 0, 0);
    send_line(COORD_MIN, 0, 0, COORD_MAX, 0, 0);
    send_line(0, 0, COORD_MAX, 0, 0, COORD_MIN);
    send_line(0, 0, 0, 2, 1, -1);
    send_line(0, 0, 0, -4, 2, -2);
    send_line(0, 0, 0, 5, -5, 3);
    send_line(0, 0, 0, 1, -7, 7);
    send_line(0, 0, 0, -9, 9, -9);
    send_line(COORD_MAX - 63, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX - 50,
              COORD_MIN + 63);
    send_line(COORD_MIN + 63, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN + 1,
              COORD_MAX - 62);
    send_line(-1, -1, -1, 30, -1, -33);
    drain();

    run_random(140, 24);
    run_random(140, 80);
    run_random(140, 0);

    repeat (70) @(posedge clk);
    $display("Run covered %0d lines (%0d empty, %0d over span) and %0d voxels, %0d mismatches",
             sb.lines_noted, sb.empty_lines, sb.span_errors, sb.voxels_checked,
             sb.mismatches);
    if (sb.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d voxels still expected", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/lvw3d_pkg.sv
rtl/lvw3d_setup.sv
rtl/lvw3d_step.sv
rtl/line_voxel_walker_3d_unit.sv
verif/tb_top.sv
